/* rtl/core/msu_pkg.sv */
// ----------------------------------------------------------------------------
// msu_pkg
// Types and constants shared by the MIDI byte stream to USB-MIDI packetizer.
// ----------------------------------------------------------------------------
package msu_pkg;

    // MIDI byte values
    localparam logic [7:0] REALTIME_MIN = 8'hF8;
    localparam logic [7:0] SYSEX_END    = 8'hF7;
    localparam logic [7:0] SYSEX_START  = 8'hF0;
    localparam logic [7:0] SYS_COMMON   = 8'hF0;

    // Status nibbles
    localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
    localparam logic [3:0] HI_NOTE_ON    = 4'h9;
    localparam logic [3:0] HI_POLY_PRESS = 4'hA;
    localparam logic [3:0] HI_CTRL       = 4'hB;
    localparam logic [3:0] HI_PROG       = 4'hC;
    localparam logic [3:0] HI_CHAN_PRESS = 4'hD;
    localparam logic [3:0] HI_PITCH      = 4'hE;

    // USB-MIDI code index numbers
    localparam logic [3:0] CIN_SYSEX_CONT = 4'h4;
    localparam logic [3:0] CIN_SYSEX_END1 = 4'h5;
    localparam logic [3:0] CIN_SYSEX_END2 = 4'h6;
    localparam logic [3:0] CIN_SYSEX_END3 = 4'h7;
    localparam logic [3:0] CIN_REALTIME   = 4'hF;

    // Input stage contents
    typedef struct packed {
        logic       vld;
        logic [7:0] data;
    } msu_in_t;

    // One USB-MIDI event packet
    typedef struct packed {
        logic       vld;
        logic [3:0] cin;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } msu_pkt_t;

endpackage

/* rtl/core/msu_in_stage.sv */
// ----------------------------------------------------------------------------
// msu_in_stage
// Input register for the serial MIDI byte; holds the word until the parser
// consumes it.
// ----------------------------------------------------------------------------
module msu_in_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             midi_valid,
    output logic             midi_stall,
    input  logic [7:0]       midi_byte_in,
    input  logic             step,
    output msu_pkg::msu_in_t cur
);

    logic       vld_reg;
    logic       vld_next;
    logic [7:0] data_reg;
    logic       take;

    // Take a word when the slot is empty or being consumed this cycle
    assign midi_stall = vld_reg && !step;
    assign take       = midi_valid && !midi_stall;

    always_comb
    begin
        vld_next = vld_reg;
        if (take)
        begin
            vld_next = 1'b1;
        end
        else if (step)
        begin
            vld_next = 1'b0;
        end
    end

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= midi_byte_in;
        end
    end

    assign cur.vld  = vld_reg;
    assign cur.data = data_reg;

endmodule

/* rtl/core/msu_parser.sv */
// ----------------------------------------------------------------------------
// msu_parser
// Parser state (running status, message and SysEx buffers) and the per-byte
// decision logic that updates it and builds at most one packet.
// ----------------------------------------------------------------------------
module msu_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        byte_in,
    output msu_pkg::msu_pkt_t pkt
);

    logic [7:0] rs_reg, rs_next;
    logic [7:0] mb_reg [3];
    logic [7:0] mb_next [3];
    logic [1:0] mf_reg, mf_next;
    logic       sx_reg, sx_next;
    logic [7:0] sb_reg [3];
    logic [7:0] sb_next [3];
    logic [1:0] sf_reg, sf_next;

    // Next state and packet for the byte being consumed
    always_comb
    begin
        logic [1:0] sidx;
        logic [1:0] mf_work;
        logic [1:0] need;
        logic [3:0] hi;
        logic       msg_touched;

        rs_next     = rs_reg;
        mb_next     = mb_reg;
        mf_next     = mf_reg;
        sx_next     = sx_reg;
        sb_next     = sb_reg;
        sf_next     = sf_reg;
        pkt         = '0;
        sidx        = (sf_reg == 2'd3) ? 2'd2 : sf_reg;
        mf_work     = mf_reg;
        need        = 2'd0;
        hi          = 4'h0;
        msg_touched = 1'b0;

        if (step)
        begin
            if (byte_in >= msu_pkg::REALTIME_MIN)
            begin
                // Real-time passes straight through
                pkt.vld = 1'b1;
                pkt.cin = msu_pkg::CIN_REALTIME;
                pkt.b0  = byte_in;
            end
            else if (sx_reg && !byte_in[7])
            begin
                // SysEx data, emit on each full triplet
                sb_next[sidx] = byte_in;
                if (sf_reg >= 2'd2)
                begin
                    sf_next = 2'd0;
                    pkt.vld = 1'b1;
                    pkt.cin = msu_pkg::CIN_SYSEX_CONT;
                    pkt.b0  = sb_next[0];
                    pkt.b1  = sb_next[1];
                    pkt.b2  = sb_next[2];
                end
                else
                begin
                    sf_next = sf_reg + 2'd1;
                end
            end
            else if (sx_reg && byte_in == msu_pkg::SYSEX_END)
            begin
                // SysEx close with 0, 1 or 2 pending bytes
                sx_next = 1'b0;
                sf_next = 2'd0;
                pkt.vld = 1'b1;
                if (sf_reg == 2'd1)
                begin
                    pkt.cin = msu_pkg::CIN_SYSEX_END2;
                    pkt.b0  = sb_reg[0];
                    pkt.b1  = msu_pkg::SYSEX_END;
                end
                else if (sf_reg == 2'd2)
                begin
                    pkt.cin = msu_pkg::CIN_SYSEX_END3;
                    pkt.b0  = sb_reg[0];
                    pkt.b1  = sb_reg[1];
                    pkt.b2  = msu_pkg::SYSEX_END;
                end
                else
                begin
                    pkt.cin = msu_pkg::CIN_SYSEX_END1;
                    pkt.b0  = msu_pkg::SYSEX_END;
                end
            end
            else
            begin
                // Any other status byte silently aborts SysEx
                if (sx_reg)
                begin
                    sx_next = 1'b0;
                    sf_next = 2'd0;
                    rs_next = 8'h00;
                end

                if (byte_in[7])
                begin
                    if (byte_in == msu_pkg::SYSEX_START)
                    begin
                        sx_next    = 1'b1;
                        sb_next[0] = msu_pkg::SYSEX_START;
                        sf_next    = 2'd1;
                        rs_next    = 8'h00;
                        mf_next    = 2'd0;
                    end
                    else
                    begin
                        rs_next     = (byte_in >= msu_pkg::SYS_COMMON) ? 8'h00 : byte_in;
                        mb_next[0]  = byte_in;
                        mf_next     = 2'd1;
                        msg_touched = 1'b1;
                    end
                end
                else if (rs_next != 8'h00)
                begin
                    // Data byte with running status
                    if (mf_work == 2'd0)
                    begin
                        mb_next[0] = rs_next;
                        mf_work    = 2'd1;
                    end
                    if (mf_work == 2'd3)
                    begin
                        mb_next[2] = byte_in;
                    end
                    else
                    begin
                        mb_next[mf_work] = byte_in;
                        mf_work          = mf_work + 2'd1;
                    end
                    mf_next     = mf_work;
                    msg_touched = 1'b1;
                end

                // Complete channel message check
                if (msg_touched)
                begin
                    hi = mb_next[0][7:4];
                    case (hi)
                        msu_pkg::HI_NOTE_OFF,
                        msu_pkg::HI_NOTE_ON,
                        msu_pkg::HI_POLY_PRESS,
                        msu_pkg::HI_CTRL,
                        msu_pkg::HI_PITCH:      need = 2'd3;
                        msu_pkg::HI_PROG,
                        msu_pkg::HI_CHAN_PRESS: need = 2'd2;
                        default:                need = 2'd0;
                    endcase
                    if (need != 2'd0 && mf_next >= need)
                    begin
                        mf_next = 2'd0;
                        pkt.vld = 1'b1;
                        pkt.cin = hi;
                        pkt.b0  = mb_next[0];
                        pkt.b1  = mb_next[1];
                        pkt.b2  = (need == 2'd3) ? mb_next[2] : 8'h00;
                    end
                end
            end
        end
    end

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_reg <= 8'h00;
            mb_reg <= '{default: 8'h00};
            mf_reg <= 2'd0;
            sx_reg <= 1'b0;
            sb_reg <= '{default: 8'h00};
            sf_reg <= 2'd0;
        end
        else
        begin
            rs_reg <= rs_next;
            mb_reg <= mb_next;
            mf_reg <= mf_next;
            sx_reg <= sx_next;
            sb_reg <= sb_next;
            sf_reg <= sf_next;
        end
    end

endmodule

/* rtl/core/msu_out_stage.sv */
// ----------------------------------------------------------------------------
// msu_out_stage
// Output register for USB-MIDI packets; holds a packet while the sink stalls.
// ----------------------------------------------------------------------------
module msu_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  msu_pkg::msu_pkt_t pkt,
    output logic              free,
    output logic              pkt_valid,
    input  logic              pkt_stall,
    output logic [3:0]        usb_cin,
    output logic [7:0]        event_byte0,
    output logic [7:0]        event_byte1,
    output logic [7:0]        event_byte2
);

    logic       vld_reg;
    logic       vld_next;
    logic [3:0] cin_reg;
    logic [7:0] b0_reg;
    logic [7:0] b1_reg;
    logic [7:0] b2_reg;

    // Slot can be refilled when empty or drained this cycle
    assign free = !vld_reg || !pkt_stall;

    always_comb
    begin
        vld_next = vld_reg;
        if (step)
        begin
            vld_next = pkt.vld;
        end
        else if (!pkt_stall)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (step && pkt.vld)
        begin
            cin_reg <= pkt.cin;
            b0_reg  <= pkt.b0;
            b1_reg  <= pkt.b1;
            b2_reg  <= pkt.b2;
        end
    end

    assign pkt_valid   = vld_reg;
    assign usb_cin     = cin_reg;
    assign event_byte0 = b0_reg;
    assign event_byte1 = b1_reg;
    assign event_byte2 = b2_reg;

endmodule

/* rtl/core/midi_stream_to_usb_packetizer.sv */
// ----------------------------------------------------------------------------
// midi_stream_to_usb_packetizer
// Serial MIDI bytes in, USB-MIDI event packets (cable 0) out.
// ----------------------------------------------------------------------------
// A byte that completes a packet is held in the input register, then its packet in
// the output register. Throughput: 1 byte per cycle while pkt_stall is low; the
// parser decides each byte combinationally between the two registers.
// Reset: rst_n clears both stage valids and all parser state (no running
// status, not in SysEx, empty buffers).
module midi_stream_to_usb_packetizer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       midi_valid,
    output logic       midi_stall,
    input  logic [7:0] midi_byte_in,
    output logic       pkt_valid,
    input  logic       pkt_stall,
    output logic [3:0] usb_cin,
    output logic [7:0] event_byte0,
    output logic [7:0] event_byte1,
    output logic [7:0] event_byte2
);

    msu_pkg::msu_in_t  cur;
    msu_pkg::msu_pkt_t pkt;
    logic              free;
    logic              step;

    // Consume the held byte when the output slot can take its packet
    assign step = cur.vld && free;

    msu_in_stage u_in (
        .clk          (clk),
        .rst_n        (rst_n),
        .midi_valid   (midi_valid),
        .midi_stall   (midi_stall),
        .midi_byte_in (midi_byte_in),
        .step         (step),
        .cur          (cur)
    );

    msu_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .byte_in (cur.data),
        .pkt     (pkt)
    );

    msu_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .pkt         (pkt),
        .free        (free),
        .pkt_valid   (pkt_valid),
        .pkt_stall   (pkt_stall),
        .usb_cin     (usb_cin),
        .event_byte0 (event_byte0),
        .event_byte1 (event_byte1),
        .event_byte2 (event_byte2)
    );

endmodule

/* rtl/core/msu_checker.sv */
// ----------------------------------------------------------------------------
// msu_checker
// Port-level checks on packets leaving the packetizer.
// ----------------------------------------------------------------------------
module msu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       pkt_valid,
    input logic       pkt_stall,
    input logic [3:0] usb_cin,
    input logic [7:0] event_byte0,
    input logic [7:0] event_byte1,
    input logic [7:0] event_byte2
);

    // Stalled packet holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && pkt_stall |=> pkt_valid && $stable(usb_cin)
            && $stable(event_byte0) && $stable(event_byte1) && $stable(event_byte2))
        else $error("stalled packet changed");

    // Codes 0..3 are never produced
    a_cin_range: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid |-> usb_cin[3] || usb_cin[2])
        else $error("reserved code index emitted");

    // Real-time packets carry a real-time byte alone
    a_realtime: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && usb_cin == msu_pkg::CIN_REALTIME |->
            event_byte0 >= msu_pkg::REALTIME_MIN && event_byte1 == 8'h00
            && event_byte2 == 8'h00)
        else $error("bad real-time packet");

    // Channel message code matches its status nibble
    a_channel: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && usb_cin[3] && usb_cin != msu_pkg::CIN_REALTIME |->
            event_byte0[7:4] == usb_cin)
        else $error("channel packet code mismatch");

    // Single-byte SysEx end is the end byte alone
    a_sx_end1: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && usb_cin == msu_pkg::CIN_SYSEX_END1 |->
            event_byte0 == msu_pkg::SYSEX_END && event_byte1 == 8'h00
            && event_byte2 == 8'h00)
        else $error("bad one-byte SysEx end");

endmodule

bind midi_stream_to_usb_packetizer msu_checker u_msu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pkt_valid    (pkt_valid),
    .pkt_stall    (pkt_stall),
    .usb_cin      (usb_cin),
    .event_byte0  (event_byte0),
    .event_byte1  (event_byte1),
    .event_byte2  (event_byte2)
);

/* tb/sv/msu_event_checker.sv */
// ----------------------------------------------------------------------------
// msu_event_checker
// Watches both channels of the MIDI-to-USB packetizer. Every accepted MIDI
// word runs through a behavioral parser (running status, SysEx triplets,
// real-time pass-through) that queues the USB-MIDI event it should cause.
// Every accepted packet is compared field by field against the oldest event
// still due.
// ----------------------------------------------------------------------------
module msu_event_checker
    import msu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       midi_valid,
    input  logic       midi_stall,
    input  logic [7:0] midi_byte_in,
    input  logic       pkt_valid,
    input  logic       pkt_stall,
    input  logic [3:0] usb_cin,
    input  logic [7:0] event_byte0,
    input  logic [7:0] event_byte1,
    input  logic [7:0] event_byte2,
    output int         fail_count,
    output int         pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [3:0] cin;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } usb_event_t;

    // parser state
    logic [7:0] live_status;
    logic [7:0] msg_buf [3];
    int         msg_cnt;
    bit         sysex_open;
    logic [7:0] sx_buf [3];
    int         sx_cnt;

    usb_event_t events_due [$];
    int         mismatches;

    function automatic usb_event_t make_event(logic [3:0] cin, logic [7:0] b0,
                                              logic [7:0] b1, logic [7:0] b2);
        usb_event_t ev;
        ev.cin = cin;
        ev.b0  = b0;
        ev.b1  = b1;
        ev.b2  = b2;
        return ev;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // One MIDI word through the parser; hit tells whether an event goes out
    task automatic parse_midi_byte(input logic [7:0] b, output bit hit,
                                   output usb_event_t ev);
        logic [3:0] hi;
        int         need;
        hit = 1'b0;
        ev  = '0;

        // real-time: straight through, nothing else touched
        if (b >= REALTIME_MIN) begin
            hit = 1'b1;
            ev  = make_event(CIN_REALTIME, b, 8'h00, 8'h00);
            return;
        end

        // SysEx payload, sent in triplets
        if (sysex_open && !b[7]) begin
            sx_buf[(sx_cnt > 2) ? 2 : sx_cnt] = b;
            sx_cnt++;
            if (sx_cnt >= 3) begin
                sx_cnt = 0;
                hit    = 1'b1;
                ev     = make_event(CIN_SYSEX_CONT, sx_buf[0], sx_buf[1], sx_buf[2]);
            end
            return;
        end

        // SysEx close, code picked by leftover count
        if (sysex_open && b == SYSEX_END) begin
            sysex_open = 1'b0;
            hit        = 1'b1;
            case (sx_cnt)
                1:       ev = make_event(CIN_SYSEX_END2, sx_buf[0], SYSEX_END, 8'h00);
                2:       ev = make_event(CIN_SYSEX_END3, sx_buf[0], sx_buf[1], SYSEX_END);
                default: ev = make_event(CIN_SYSEX_END1, SYSEX_END, 8'h00, 8'h00);
            endcase
            sx_cnt = 0;
            return;
        end

        // any other status inside SysEx drops it quietly
        if (sysex_open) begin
            sysex_open  = 1'b0;
            sx_cnt      = 0;
            live_status = 8'h00;
        end

        if (b[7]) begin
            if (b == SYSEX_START) begin
                sysex_open  = 1'b1;
                sx_buf[0]   = SYSEX_START;
                sx_cnt      = 1;
                live_status = 8'h00;
                msg_cnt     = 0;
                return;
            end
            live_status = (b >= SYS_COMMON) ? 8'h00 : b;
            msg_buf[0]  = b;
            msg_cnt     = 1;
        end else begin
            if (live_status == 8'h00)
                return;
            if (msg_cnt == 0) begin
                msg_buf[0] = live_status;
                msg_cnt    = 1;
            end
            if (msg_cnt >= 3) begin
                msg_buf[2] = b;
            end else begin
                msg_buf[msg_cnt] = b;
                msg_cnt++;
            end
        end

        // channel message complete?
        hi = msg_buf[0][7:4];
        case (hi)
            HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_PRESS, HI_CTRL, HI_PITCH: need = 3;
            HI_PROG, HI_CHAN_PRESS:                                   need = 2;
            default:                                                  need = 0;
        endcase
        if (need > 0 && msg_cnt >= need) begin
            msg_cnt = 0;
            hit     = 1'b1;
            ev      = make_event(hi, msg_buf[0], msg_buf[1],
                                 (need == 3) ? msg_buf[2] : 8'h00);
        end
    endtask

    // Predict on accepted input words, compare on accepted packets
    always @(posedge clk or negedge rst_n)
    begin
        usb_event_t fresh;
        usb_event_t due;
        bit         hit;
        if (!rst_n) begin
            live_status = 8'h00;
            msg_buf     = '{8'h00, 8'h00, 8'h00};
            msg_cnt     = 0;
            sysex_open  = 1'b0;
            sx_buf      = '{8'h00, 8'h00, 8'h00};
            sx_cnt      = 0;
            events_due.delete();
            mismatches  = 0;
            fail_count    <= 0;
            pending_count <= 0;
        end else begin
            if (midi_valid === 1'b1 && midi_stall === 1'b0) begin
                parse_midi_byte(midi_byte_in, hit, fresh);
                if (hit)
                    events_due.push_back(fresh);
            end
            if (pkt_valid === 1'b1 && pkt_stall === 1'b0) begin
                if (events_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected packet %h %h %h %h",
                        usb_cin, event_byte0, event_byte1, event_byte2));
                end else begin
                    due = events_due.pop_front();
                    if (usb_cin !== due.cin)
                        report_mismatch($sformatf("usb_cin got %h want %h",
                            usb_cin, due.cin));
                    if (event_byte0 !== due.b0)
                        report_mismatch($sformatf("event_byte0 got %h want %h",
                            event_byte0, due.b0));
                    if (event_byte1 !== due.b1)
                        report_mismatch($sformatf("event_byte1 got %h want %h",
                            event_byte1, due.b1));
                    if (event_byte2 !== due.b2)
                        report_mismatch($sformatf("event_byte2 got %h want %h",
                            event_byte2, due.b2));
                end
            end
            pending_count <= events_due.size();
            fail_count    <= mismatches;
        end
    end

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives the MIDI-to-USB packetizer with a directed opening (real-time,
// message kinds bar note-off and control change, running status, SysEx closes
// and aborts) and then random phrases, mostly well-formed with noise mixed in.
// Both sides idle at random; the packet side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import msu_pkg::*;

    localparam time CLK_PERIOD   = 10ns;
    localparam int  RANDOM_WORDS = 650;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  TAIL_CYCLES  = 12;
    localparam int  CYCLE_LIMIT  = 300000;

    // byte ranges used by the stimulus
    localparam logic [7:0] DATA_MAX     = 8'h7F;
    localparam logic [7:0] CHAN_FIRST   = 8'h80;
    localparam logic [7:0] CHAN_LAST    = 8'hEF;
    localparam logic [7:0] COMMON_FIRST = 8'hF1;
    localparam logic [7:0] COMMON_LAST  = 8'hF6;
    localparam logic [7:0] SONG_SELECT  = 8'hF3;
    localparam logic [7:0] ACTIVE_SENSE = 8'hFE;
    localparam logic [7:0] REALTIME_MAX = 8'hFF;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       midi_valid;
    logic       midi_stall;
    logic [7:0] midi_byte_in;
    logic       pkt_valid;
    logic       pkt_stall;
    logic [3:0] usb_cin;
    logic [7:0] event_byte0;
    logic [7:0] event_byte1;
    logic [7:0] event_byte2;
    int         fail_count;
    int         pending_count;

    int         sent;
    int         cycle_cnt = 0;
    bit         gaps_on = 1'b1;
    bit         hold_req = 1'b0;
    bit         holding = 1'b0;
    bit         hold_done = 1'b0;
    bit         drain_done = 1'b0;
    logic [7:0] byte_plan [$];
    logic [7:0] warmup_bytes [$];

    always #(CLK_PERIOD / 2) clk = ~clk;

    midi_stream_to_usb_packetizer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .midi_valid   (midi_valid),
        .midi_stall   (midi_stall),
        .midi_byte_in (midi_byte_in),
        .pkt_valid    (pkt_valid),
        .pkt_stall    (pkt_stall),
        .usb_cin      (usb_cin),
        .event_byte0  (event_byte0),
        .event_byte1  (event_byte1),
        .event_byte2  (event_byte2)
    );

    msu_event_checker i_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .midi_valid    (midi_valid),
        .midi_stall    (midi_stall),
        .midi_byte_in  (midi_byte_in),
        .pkt_valid     (pkt_valid),
        .pkt_stall     (pkt_stall),
        .usb_cin       (usb_cin),
        .event_byte0   (event_byte0),
        .event_byte1   (event_byte1),
        .event_byte2   (event_byte2),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Offer one word and hold it until taken
    task automatic send_byte(input logic [7:0] b);
        midi_valid   <= 1'b1;
        midi_byte_in <= b;
        @(posedge clk);
        while (midi_stall !== 1'b0)
            @(posedge clk);
        sent++;
    endtask

    // Sender gap: mostly none, some short, a few long
    task automatic idle_gap();
        int r;
        int len;
        if (!gaps_on || holding)
            return;
        r = $urandom_range(0, 99);
        if (r < 65)
            len = 0;
        else if (r < 95)
            len = $urandom_range(1, 3);
        else
            len = $urandom_range(10, 40);
        if (len != 0) begin
            midi_valid <= 1'b0;
            repeat (len) @(posedge clk);
        end
    endtask

    // Stop sending until every due packet has come out
    task automatic drain_results();
        midi_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] data_byte();
        return 8'($urandom_range(0, DATA_MAX));
    endfunction

    // Queue a word, now and then with a real-time byte slipped in ahead
    task automatic add_byte(input logic [7:0] b);
        if ($urandom_range(0, 15) == 0)
            byte_plan.push_back(8'($urandom_range(REALTIME_MIN, REALTIME_MAX)));
        byte_plan.push_back(b);
    endtask

    // One random phrase: channel message, SysEx, system common, stray end, noise
    task automatic plan_phrase();
        logic [7:0] st;
        int         kind;
        int         reps;
        int         n;
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            st = 8'($urandom_range(CHAN_FIRST, CHAN_LAST));
            // a missing status leans on whatever running status is live
            if ($urandom_range(0, 3) != 0)
                add_byte(st);
            reps = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
            n = (st[7:4] == HI_PROG || st[7:4] == HI_CHAN_PRESS) ? 1 : 2;
            repeat (reps * n) add_byte(data_byte());
        end else if (kind < 70) begin
            add_byte(SYSEX_START);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 5);
            repeat (n) add_byte(data_byte());
            if ($urandom_range(0, 7) == 0)
                add_byte(8'($urandom_range(CHAN_FIRST, COMMON_LAST)));
            else
                add_byte(SYSEX_END);
        end else if (kind < 80) begin
            add_byte(8'($urandom_range(COMMON_FIRST, COMMON_LAST)));
            repeat ($urandom_range(0, 2)) add_byte(data_byte());
        end else if (kind < 88) begin
            add_byte(SYSEX_END);
        end else begin
            repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Packet side: random stalls, calm stretches, one long hold-off
    initial
    begin
        int r;
        int len;
        pkt_stall <= 1'b0;
        @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                holding  = 1'b1;
                pkt_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                holding = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    pkt_stall <= 1'b0;
                    len = $urandom_range(50, 150);
                end else if (r < 60) begin
                    pkt_stall <= 1'b0;
                    len = $urandom_range(1, 8);
                end else if (r < 95) begin
                    pkt_stall <= 1'b1;
                    len = $urandom_range(1, 3);
                end else begin
                    pkt_stall <= 1'b1;
                    len = $urandom_range(10, 40);
                end
                repeat (len) @(posedge clk);
            end
        end
    end

    // MIDI side and verdict
    initial
    begin
        rst_n        <= 1'b0;
        midi_valid   <= 1'b0;
        midi_byte_in <= 8'h00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // real-time, orphan data, message kinds bar note-off and control change,
        // running status, one-leftover SysEx closes, SysEx aborted by a status
        warmup_bytes = '{
            REALTIME_MIN, REALTIME_MAX, 8'h55,
            {HI_NOTE_ON, 4'h0}, 8'h3C, DATA_MAX, 8'h00, DATA_MAX,
            {HI_POLY_PRESS, 4'hF}, 8'h01, 8'h02,
            {HI_PROG, 4'h5}, DATA_MAX,
            {HI_CHAN_PRESS, 4'h0},
            {HI_PITCH, 4'h1}, 8'h00, DATA_MAX,
            SYSEX_START, 8'h01, ACTIVE_SENSE, 8'h02, 8'h03, SYSEX_END,
            SYSEX_START, SYSEX_END,
            SYSEX_START, SONG_SELECT, 8'h40
        };
        foreach (warmup_bytes[i]) begin
            send_byte(warmup_bytes[i]);
            idle_gap();
        end
        drain_results();

        sent = 0;
        while (sent < RANDOM_WORDS) begin
            plan_phrase();
            while (byte_plan.size() != 0) begin
                send_byte(byte_plan.pop_front());
                idle_gap();
            end
            if ($urandom_range(0, 9) == 0)
                gaps_on = !gaps_on;
            if (!hold_done && sent >= 250) begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
            end
            if (!drain_done && sent >= 450) begin
                drain_done = 1'b1;
                drain_results();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/core/msu_pkg.sv
rtl/core/msu_in_stage.sv
rtl/core/msu_parser.sv
rtl/core/msu_out_stage.sv
rtl/core/midi_stream_to_usb_packetizer.sv
rtl/core/msu_checker.sv
tb/sv/msu_event_checker.sv
tb/sv/tb_top.sv
